### rtl/crc8_frame_parser_assert.svh
// Assertion macros used by the checker file of the frame parser.
`ifndef CRC8_FRAME_PARSER_ASSERT_SVH
`define CRC8_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC8FP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc8 frame parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRC8FP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc8 frame parser: next-cycle check failed");

`endif

### rtl/crc8fp_pkg.sv
// Package of the frame parser: constants, register indexes, control structs, CRC step.
package crc8fp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;

  localparam logic [7:0] STX_BYTE = 8'hAA;
  localparam logic [7:0] ETX_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STATUS_CMD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_LEN = 1'd1;

  localparam logic [7:0] STATUS_CMD_RST = 8'h81;
  localparam logic [4:0] STATUS_LEN_RST = 5'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_len;
    logic load_cmd;
    logic wr_payload;
    logic load_rcrc;
    logic clr_emit;
    logic rd_payload;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_stx;
    logic len_ok;
    logic len_zero;
    logic fill_done;
    logic frame_ok;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  // One CRC-8 update over a byte, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] val);
    logic [7:0] c;
    c = acc ^ val;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/crc8fp_if.sv
// Valid/ready channel interfaces for received bytes and emitted payload beats.
interface crc8fp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8fp_pl_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [3:0] byte_index;
  logic       last;

  modport source (output valid, output payload_byte, output byte_index, output last,
                  input ready);
  modport sink (input valid, input payload_byte, input byte_index, input last,
                output ready);
endinterface

### rtl/crc8fp_ram.sv
// Generic single-port RAM with registered read data.
module crc8fp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/crc8fp_dpath.sv
// Datapath of the frame parser: frame registers, CRC, payload store, output register.
module crc8fp_dpath import crc8fp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  out_ready_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  output logic [7:0]            payload_byte_o,
  output logic [3:0]            byte_index_o,
  output logic                  last_o
);

  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned IDX_W = (AW > 5) ? AW : 5;

  logic [7:0] status_cmd_q, status_cmd_d;
  logic [4:0] status_len_q, status_len_d;
  logic [4:0] frame_len_q, frame_len_d;
  logic [7:0] frame_cmd_q, frame_cmd_d;
  logic [4:0] fill_q, fill_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] rcrc_q, rcrc_d;
  logic [4:0] emit_q, emit_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [3:0] out_idx_q, out_idx_d;
  logic       out_last_q, out_last_d;

  logic [4:0]       fill_inc;
  logic [4:0]       emit_inc;
  logic [IDX_W-1:0] fill_ext;
  logic [IDX_W-1:0] emit_ext;
  logic [AW-1:0]    ram_addr;
  logic             ram_we;
  logic [7:0]       ram_rdata;

  assign fill_inc = fill_q + 5'd1;
  assign emit_inc = emit_q + 5'd1;
  assign fill_ext = IDX_W'(fill_q);
  assign emit_ext = IDX_W'(emit_q);

  // Writes beyond the store are dropped; reads only happen during emission.
  assign ram_we   = cmd_i.wr_payload && ({3'd0, fill_q} < 8'(MAX_PAYLOAD));
  assign ram_addr = cmd_i.wr_payload ? fill_ext[AW-1:0] : emit_ext[AW-1:0];

  crc8fp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd_payload),
    .addr_i  (ram_addr),
    .wdata_i (rx_byte_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    status_cmd_d = status_cmd_q;
    status_len_d = status_len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STATUS_CMD: status_cmd_d = cfg_data_i;
        REG_STATUS_LEN: status_len_d = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_len_d = frame_len_q;
    frame_cmd_d = frame_cmd_q;
    fill_d      = fill_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    emit_d      = emit_q;
    if (cmd_i.load_len) begin
      frame_len_d = rx_byte_i[4:0];
      fill_d      = '0;
      crc_d       = crc8_step(8'd0, rx_byte_i);
    end
    if (cmd_i.load_cmd) begin
      frame_cmd_d = rx_byte_i;
      crc_d       = crc8_step(crc_q, rx_byte_i);
    end
    if (cmd_i.wr_payload) begin
      fill_d = fill_inc;
      crc_d  = crc8_step(crc_q, rx_byte_i);
    end
    if (cmd_i.load_rcrc) begin
      rcrc_d = rx_byte_i;
    end
    if (cmd_i.clr_emit) begin
      emit_d = '0;
    end else if (cmd_i.load_out) begin
      emit_d = emit_inc;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_byte_d  = ram_rdata;
      out_idx_d   = emit_q[3:0];
      out_last_d  = (emit_inc == frame_len_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_cmd_q <= STATUS_CMD_RST;
      status_len_q <= STATUS_LEN_RST;
      frame_len_q  <= '0;
      frame_cmd_q  <= '0;
      fill_q       <= '0;
      crc_q        <= '0;
      rcrc_q       <= '0;
      emit_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      status_cmd_q <= status_cmd_d;
      status_len_q <= status_len_d;
      frame_len_q  <= frame_len_d;
      frame_cmd_q  <= frame_cmd_d;
      fill_q       <= fill_d;
      crc_q        <= crc_d;
      rcrc_q       <= rcrc_d;
      emit_q       <= emit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign status_o.is_stx    = (rx_byte_i == STX_BYTE);
  assign status_o.len_ok    = (rx_byte_i <= 8'(MAX_PAYLOAD));
  assign status_o.len_zero  = (frame_len_q == 5'd0);
  assign status_o.fill_done = (fill_inc >= frame_len_q);
  assign status_o.frame_ok  = (rx_byte_i == ETX_BYTE) && (rcrc_q == crc_q) &&
                              (frame_cmd_q == status_cmd_q) &&
                              (frame_len_q == status_len_q);
  assign status_o.emit_last = (emit_inc == frame_len_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign last_o         = out_last_q;

endmodule

### rtl/crc8fp_ctrl.sv
// Controller of the frame parser: frame phase sequencing and payload emission.
module crc8fp_ctrl import crc8fp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_CMD  = 3'd2;
  localparam logic [2:0] ST_PAY  = 3'd3;
  localparam logic [2:0] ST_CRC  = 3'd4;
  localparam logic [2:0] ST_ETX  = 3'd5;
  localparam logic [2:0] ST_RD   = 3'd6;
  localparam logic [2:0] ST_LD   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        in_ready_o = 1'b1;
        if (in_acc_i && status_i.is_stx) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          if (status_i.len_ok) begin
            cmd_o.load_len = 1'b1;
            state_d        = ST_CMD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_CMD: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = status_i.len_zero ? ST_CRC : ST_PAY;
        end
      end
      ST_PAY: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          cmd_o.wr_payload = 1'b1;
          if (status_i.fill_done) begin
            state_d = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          cmd_o.load_rcrc = 1'b1;
          state_d         = ST_ETX;
        end
      end
      ST_ETX: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          if (status_i.frame_ok && !status_i.len_zero) begin
            cmd_o.clr_emit = 1'b1;
            state_d        = ST_RD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_payload = 1'b1;
        state_d          = ST_LD;
      end
      ST_LD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = status_i.emit_last ? ST_HUNT : ST_RD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/crc8_frame_parser.sv
// Top level of the CRC-8 frame parser.
//
// This block deframes a received byte stream of the form start byte 0xAA, length, command,
// payload, CRC-8 (polynomial 0x07, initial value zero, over length, command and payload) and
// terminator 0x55. A length above MAX_PAYLOAD sends it back to hunting for the start byte.
// A frame is accepted only when the terminator, the CRC, the command and the length all match,
// the last two against the status_command and status_length registers (index 0 and 1 of the
// write port). Rejected frames produce nothing. For an accepted frame the stored payload is
// sent out one beat per byte with its index and a last flag on the final byte. Throughput:
// while a frame is being received, one byte beat is taken every cycle. Once a frame with N
// payload bytes is accepted, the input is held off while the payload store is read back; each
// byte is first read from the single-port payload RAM into its read register, then loaded into
// the output register once that is free, so backpressure from the output side lengthens the
// hold-off. The output register lets the next frame start while the final beat still waits.
// Configuration registers should only be written while no frame is being emitted.
module crc8_frame_parser import crc8fp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  crc8fp_rx_if.sink             rx_i,
  crc8fp_pl_if.source           pl_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_acc;

  // A byte beat is taken whenever the controller is receiving and the source offers one.
  assign rx_i.ready = in_ready;
  assign in_acc     = rx_i.valid && in_ready;

  crc8fp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  crc8fp_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_i.rx_byte),
    .out_ready_i    (pl_o.ready),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (pl_o.valid),
    .payload_byte_o (pl_o.payload_byte),
    .byte_index_o   (pl_o.byte_index),
    .last_o         (pl_o.last)
  );

endmodule

### rtl/crc8fp_checker.sv
// Port-level checker of the frame parser and its bind to the top level.
`include "crc8_frame_parser_assert.svh"

module crc8fp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_i,
  input logic [3:0] byte_index_i,
  input logic       last_i
);

  logic        out_acc;
  logic        out_stall;
  logic [12:0] out_beat;
  logic [3:0]  exp_idx_q, exp_idx_d;

  assign out_acc   = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_beat  = {payload_byte_i, byte_index_i, last_i};

  // Beats of one frame count up from zero; a last beat restarts the count.
  always_comb begin
    exp_idx_d = exp_idx_q;
    if (out_acc) begin
      exp_idx_d = last_i ? 4'd0 : (byte_index_i + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else begin
      exp_idx_q <= exp_idx_d;
    end
  end

  `CRC8FP_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `CRC8FP_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_stall, $stable(out_beat))
  `CRC8FP_ASSERT_SAME(a_index_seq, clk_i, rst_ni, out_acc, byte_index_i == exp_idx_q)
  `CRC8FP_ASSERT_SAME(a_rx_held_in_frame, clk_i, rst_ni, out_valid_i && !last_i, !rx_ready_i)

endmodule

bind crc8_frame_parser crc8fp_checker u_crc8fp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_ready_i     (rx_i.ready),
  .out_valid_i    (pl_o.valid),
  .out_ready_i    (pl_o.ready),
  .payload_byte_i (pl_o.payload_byte),
  .byte_index_i   (pl_o.byte_index),
  .last_i         (pl_o.last)
);

### tb/tb_crc8_frame_parser.sv
// Self-checking testbench of the CRC-8 frame parser: framed byte stimulus and payload beat checks.
module tb_crc8_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import crc8fp_pkg::*;

  // Cycles allowed for the whole run. A correct run stays well below this limit,
  // so it only catches a hung block.
  localparam int unsigned CYCLE_LIMIT = 100000;
  // Emitting a full frame takes longer the larger the payload store, so this many
  // cycles after the last payload beat the block is sure to be back at rest.
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_PAYLOAD_DEF + 8;
  // Least count of frame bytes (hunting noise excluded) the random traffic test sends.
  localparam int unsigned RANDOM_FRAME_BYTES = 36;

  // Receive phases of the frame, as the block walks through them.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_PAYLOAD,
    PH_CRC,
    PH_ETX
  } rx_phase_e;

  // How the payload side takes beats when no long hold-off is running.
  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  // Kinds of frames that the random traffic mixes.
  typedef enum logic [2:0] {
    FK_GOOD,
    FK_BAD_CRC,
    FK_BAD_ETX,
    FK_OTHER_CMD,
    FK_OTHER_LEN,
    FK_OVERSIZE,
    FK_NOISE
  } frame_kind_e;

  // One payload beat as the block should present it.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic       last;
  } payload_beat_t;

  typedef logic [7:0] byte_q_t[$];

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  crc8fp_rx_if rx_if ();
  crc8fp_pl_if pl_if ();

  crc8_frame_parser u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .pl_o       (pl_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the deframer. It follows every accepted byte beat and
  // queues the payload beats that an accepted frame must produce.
  // ---------------------------------------------------------------------------
  rx_phase_e     shadow_phase;
  logic [4:0]    shadow_len;
  logic [7:0]    shadow_cmd;
  logic [4:0]    shadow_fill;
  logic [7:0]    shadow_crc;
  logic [7:0]    shadow_rx_crc;
  logic [7:0]    shadow_store[MAX_PAYLOAD_DEF];
  logic [7:0]    want_cmd;
  logic [4:0]    want_len;
  payload_beat_t beats_due[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned frame_bytes = 0;

  // Sender pacing: bursts of random length separated by gaps of up to gap_max.
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;

  // Receiver pacing.
  sink_mode_e  sink_mode = SINK_ALWAYS;
  int unsigned sink_hold = 0;
  int unsigned sink_tick = 0;

  // CRC-8, polynomial 0x07, fed one bit at a time from the most significant
  // bit. This serial form gives the same remainder as the byte-wise update.
  function automatic logic [7:0] crc8_serial(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Advances the shadow deframer by one received byte. The payload beats are
  // queued in the same step that takes the terminator, which is how the block
  // decides acceptance too.
  function automatic void track_rx_byte(input logic [7:0] b);
    payload_beat_t beat;
    case (shadow_phase)
      PH_HUNT: begin
        if (b == STX_BYTE) begin
          shadow_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        // An oversized length just drops back to the hunt; the byte itself is
        // not looked at again as a possible start byte.
        if (b > MAX_PAYLOAD_DEF) begin
          shadow_phase = PH_HUNT;
        end else begin
          shadow_len   = b[4:0];
          shadow_fill  = '0;
          shadow_crc   = crc8_serial(8'h00, b);
          shadow_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        shadow_cmd   = b;
        shadow_crc   = crc8_serial(shadow_crc, b);
        // With a zero length the CRC byte follows the command directly.
        shadow_phase = (shadow_len == 5'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (shadow_fill < MAX_PAYLOAD_DEF) begin
          shadow_store[shadow_fill[3:0]] = b;
        end
        shadow_fill = shadow_fill + 5'd1;
        shadow_crc  = crc8_serial(shadow_crc, b);
        if (shadow_fill >= shadow_len) begin
          shadow_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        shadow_rx_crc = b;
        shadow_phase  = PH_ETX;
      end
      PH_ETX: begin
        shadow_phase = PH_HUNT;
        // An accepted frame of length zero is legal and simply yields nothing.
        if (b == ETX_BYTE && shadow_rx_crc == shadow_crc &&
            shadow_cmd == want_cmd && shadow_len == want_len) begin
          for (int i = 0; i < shadow_len && i < MAX_PAYLOAD_DEF; i++) begin
            beat.payload_byte = shadow_store[i];
            beat.byte_index   = i[3:0];
            beat.last         = (i + 1 == shadow_len);
            beats_due.push_back(beat);
          end
        end
      end
      default: begin
        shadow_phase = PH_HUNT;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and reporting.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Every payload beat taken by the receiver is compared with the oldest beat
  // still due. Flops update after this block reads them, so the values seen
  // here are the ones present at the edge.
  always @(posedge clk_i) begin
    payload_beat_t due;
    if (rst_ni && pl_if.valid && pl_if.ready) begin
      if (beats_due.size() == 0) begin
        report_mismatch("payload beat with nothing due", pl_if.payload_byte, 0);
      end else begin
        due = beats_due.pop_front();
        if (pl_if.payload_byte !== due.payload_byte) begin
          report_mismatch("payload_byte", pl_if.payload_byte, due.payload_byte);
        end
        if (pl_if.byte_index !== due.byte_index) begin
          report_mismatch("byte_index", pl_if.byte_index, due.byte_index);
        end
        if (pl_if.last !== due.last) begin
          report_mismatch("last", pl_if.last, due.last);
        end
      end
    end
  end

  // Watchdog: a stuck handshake or a missing beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] Timeout with %0d payload beats still due", $realtime, beats_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver ready. A long hold-off counts down here on its own; otherwise the
  // chosen mode decides. The pattern mode stalls in a repeating pattern.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      pl_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      case (sink_mode)
        SINK_ALWAYS:  pl_if.ready <= 1'b1;
        SINK_RANDOM:  pl_if.ready <= ($urandom_range(0, 2) != 0);
        SINK_PATTERN: pl_if.ready <= ((sink_tick % 5) >= 2);
        default:      pl_if.ready <= 1'b1;
      endcase
    end
    sink_tick++;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one byte beat and returns at the edge where it is taken. Valid stays
  // high after the beat, so back-to-back beats never drop it in between; a gap
  // lowers it at a later falling edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'($urandom_range(0, 255));
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do begin
      @(posedge clk_i);
    end while (!rx_if.ready);
    track_rx_byte(b);
  endtask

  function automatic byte_q_t random_body(input int unsigned n);
    byte_q_t body;
    for (int unsigned i = 0; i < n; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  // Sends a complete frame with the given command and payload. A nonzero
  // crc_flip corrupts the CRC byte; term is the closing byte.
  task automatic send_frame(input logic [7:0] cmd, input byte_q_t body,
                            input logic [7:0] crc_flip, input logic [7:0] term);
    logic [7:0] crc;
    logic [7:0] len;
    len = 8'(body.size());
    crc = crc8_serial(8'h00, len);
    crc = crc8_serial(crc, cmd);
    send_byte(STX_BYTE);
    send_byte(len);
    send_byte(cmd);
    foreach (body[i]) begin
      crc = crc8_serial(crc, body[i]);
      send_byte(body[i]);
    end
    send_byte(crc ^ crc_flip);
    send_byte(term);
    frame_bytes += body.size() + 5;
  endtask

  // Waits until every due beat has come out, then lets the block settle so
  // that a rejected frame still in flight cannot meet a register write.
  task automatic wait_idle();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    burst_left = 0;
    while (beats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    // The length register keeps only its low five bits.
    if (idx == REG_STATUS_CMD) begin
      want_cmd = data;
    end else begin
      want_len = data[4:0];
    end
  endtask

  task automatic apply_config(input logic [7:0] cmd, input logic [7:0] len_data);
    wait_idle();
    write_reg(REG_STATUS_CMD, cmd);
    write_reg(REG_STATUS_LEN, len_data);
  endtask

  // Picks one frame of a random kind against the current register settings.
  // Most frames are well formed and accepted; the rest are broken on purpose.
  task automatic send_random_frame();
    int unsigned roll;
    frame_kind_e kind;
    logic [7:0]  other;
    int unsigned n;
    roll = $urandom_range(0, 99);
    if (roll < 60) kind = FK_GOOD;
    else if (roll < 68) kind = FK_BAD_CRC;
    else if (roll < 76) kind = FK_BAD_ETX;
    else if (roll < 84) kind = FK_OTHER_CMD;
    else if (roll < 92) kind = FK_OTHER_LEN;
    else if (roll < 96) kind = FK_OVERSIZE;
    else kind = FK_NOISE;
    case (kind)
      FK_GOOD: begin
        send_frame(want_cmd, random_body(want_len), 8'h00, ETX_BYTE);
      end
      FK_BAD_CRC: begin
        send_frame(want_cmd, random_body(want_len), 8'($urandom_range(1, 255)), ETX_BYTE);
      end
      FK_BAD_ETX: begin
        other = 8'($urandom_range(0, 255));
        if (other == ETX_BYTE) begin
          other = ~ETX_BYTE;
        end
        send_frame(want_cmd, random_body(want_len), 8'h00, other);
      end
      FK_OTHER_CMD: begin
        other = want_cmd ^ 8'($urandom_range(1, 255));
        send_frame(other, random_body(want_len), 8'h00, ETX_BYTE);
      end
      FK_OTHER_LEN: begin
        do begin
          n = $urandom_range(0, MAX_PAYLOAD_DEF);
        end while (n == want_len);
        send_frame(want_cmd, random_body(n), 8'h00, ETX_BYTE);
      end
      FK_OVERSIZE: begin
        send_byte(STX_BYTE);
        send_byte(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
        frame_bytes += 2;
      end
      default: begin
        // Line noise between frames; start bytes are kept out so the next
        // frame is still found cleanly.
        repeat ($urandom_range(1, 4)) begin
          other = 8'($urandom_range(0, 255));
          send_byte((other == STX_BYTE) ? 8'h00 : other);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset register values, an oversized length equal to the start byte (which
  // must not restart a frame), the smallest oversized length, and a frame whose
  // payload carries the start and stop bytes and both byte extremes.
  task automatic test_directed_frames();
    byte_q_t body;
    gap_max   = 0;
    sink_mode = SINK_ALWAYS;
    send_byte(STX_BYTE);
    send_byte(STX_BYTE);
    send_byte(STX_BYTE);
    send_byte(8'(MAX_PAYLOAD_DEF + 1));
    body = '{8'hAA, 8'h00, 8'hFF, 8'h55, 8'h80, 8'h7F, 8'h01, 8'hFE};
    send_frame(STATUS_CMD_RST, body, 8'h00, ETX_BYTE);
  endtask

  // Walks the registers through their extremes: the shortest and longest
  // lengths, an empty frame that is accepted yet emits nothing, and a length
  // that no frame can ever reach.
  task automatic test_config_extremes();
    gap_max   = 2;
    sink_mode = SINK_RANDOM;

    apply_config(8'h00, 8'd1);
    send_frame(8'h00, random_body(1), 8'h00, ETX_BYTE);
    send_frame(8'h01, random_body(1), 8'h00, ETX_BYTE);

    // The upper bits of the length write are dropped, leaving 16.
    apply_config(8'hFF, 8'hF0);
    send_frame(8'hFF, random_body(16), 8'h00, ETX_BYTE);
    send_frame(8'hFF, random_body(16), 8'h00, 8'hD5);

    apply_config(8'h81, 8'h00);
    send_frame(8'h81, random_body(0), 8'h00, ETX_BYTE);
    send_frame(8'h81, random_body(1), 8'h00, ETX_BYTE);

    apply_config(8'h5A, 8'h1F);
    send_frame(8'h5A, random_body(16), 8'h00, ETX_BYTE);
    send_frame(8'h5A, random_body(15), 8'h00, ETX_BYTE);
  endtask

  // The receiver holds off for a long stretch while full-size frames keep
  // coming, so the output register and the payload store fill up and the
  // block has to stall its byte input.
  task automatic test_output_backpressure();
    apply_config(8'hC3, 8'd16);
    gap_max   = 0;
    sink_mode = SINK_PATTERN;
    sink_hold = 300;
    repeat (2) send_frame(8'hC3, random_body(16), 8'h00, ETX_BYTE);
  endtask

  // Random frames in three rounds, each with fresh register values and its own
  // pacing: no idling at all, then random gaps and stalls, then a fixed stall
  // pattern with short gaps.
  task automatic test_random_traffic();
    int unsigned round_target;
    for (int round = 0; round < 3; round++) begin
      apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, MAX_PAYLOAD_DEF)));
      case (round)
        0: begin
          gap_max   = 0;
          sink_mode = SINK_ALWAYS;
        end
        1: begin
          gap_max   = 6;
          sink_mode = SINK_RANDOM;
        end
        default: begin
          gap_max   = 3;
          sink_mode = SINK_PATTERN;
        end
      endcase
      frame_bytes  = 0;
      round_target = RANDOM_FRAME_BYTES / 3;
      while (frame_bytes < round_target) begin
        send_random_frame();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_STATUS_CMD;
    cfg_data_i    = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    pl_if.ready   = 1'b0;

    shadow_phase  = PH_HUNT;
    shadow_len    = '0;
    shadow_cmd    = '0;
    shadow_fill   = '0;
    shadow_crc    = '0;
    shadow_rx_crc = '0;
    want_cmd      = STATUS_CMD_RST;
    want_len      = STATUS_LEN_RST;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed_frames();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();

    // Drain: every due beat must arrive, then a quiet spell in which nothing
    // more may come out.
    wait_idle();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/crc8fp_pkg.sv
rtl/crc8fp_if.sv
rtl/crc8fp_ram.sv
rtl/crc8fp_dpath.sv
rtl/crc8fp_ctrl.sv
rtl/crc8_frame_parser.sv
rtl/crc8fp_checker.sv
tb/tb_crc8_frame_parser.sv
